// File: rtl/core/sbmq_pkg.sv
// Shared types, codes and defaults for the shared-buffer multi-queue.
package sbmq_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned QUEUES_DEF  = 4;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned QIDX_W = 2;

  localparam logic signed [DATA_W-1:0] DATA_ZERO      = '0;
  localparam logic signed [DATA_W-1:0] DATA_UNDERFLOW = '1;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic read_enq;
    logic read_deq;
    logic commit_enq;
    logic link_tail;
    logic commit_deq;
    logic set_ovf;
    logic set_udf;
    logic load_out;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_deq;
    logic q_valid;
    logic q_nonempty;
    logic free_empty;
  } dp_stat_t;

endpackage

// File: rtl/core/sbmq_if.sv
// Request and response channel interfaces of the shared-buffer multi-queue.
interface sbmq_in_if;
  logic                                 valid;
  logic                                 ready;
  sbmq_pkg::cmd_e                       command;
  logic [sbmq_pkg::QIDX_W-1:0]          queue_index;
  logic signed [sbmq_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, command, queue_index, write_data, input ready);
  modport sink   (input valid, command, queue_index, write_data, output ready);
endinterface

interface sbmq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbmq_pkg::DATA_W-1:0]   read_data;
  sbmq_pkg::status_e                    status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

// File: rtl/core/sbmq_ctrl.sv
// Sequencer for one enqueue or dequeue item at a time, plus output handshake.
module sbmq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  sbmq_pkg::dp_stat_t stat_i,
  output sbmq_pkg::ctl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_ENQ  = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_DEQ  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_d, state_q;
  logic       out_valid_d, out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!stat_i.is_deq) begin
          if (!stat_i.q_valid || stat_i.free_empty) begin
            cmd_o.set_ovf = 1'b1;
            state_d       = S_OUT;
          end else begin
            cmd_o.read_enq = 1'b1;
            state_d        = S_ENQ;
          end
        end else if (!stat_i.q_nonempty) begin
          cmd_o.set_udf = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd_o.read_deq = 1'b1;
          state_d        = S_DEQ;
        end
      end
      S_ENQ: begin
        cmd_o.commit_enq = 1'b1;
        // old tail still needs its next pointer patched
        state_d = stat_i.q_nonempty ? S_LINK : S_OUT;
      end
      S_LINK: begin
        cmd_o.link_tail = 1'b1;
        state_d         = S_OUT;
      end
      S_DEQ: begin
        cmd_o.commit_deq = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/sbmq_dp.sv
// Datapath: queue pointer memory, link memory with free list, data memory.
module sbmq_dp #(
  parameter int unsigned ENTRIES = sbmq_pkg::ENTRIES_DEF,
  parameter int unsigned QUEUES  = sbmq_pkg::QUEUES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sbmq_pkg::ctl_cmd_t                 cmd_i,
  output sbmq_pkg::dp_stat_t                 stat_o,
  input  sbmq_pkg::cmd_e                     in_command_i,
  input  logic [sbmq_pkg::QIDX_W-1:0]        in_queue_index_i,
  input  logic signed [sbmq_pkg::DATA_W-1:0] in_write_data_i,
  output logic signed [sbmq_pkg::DATA_W-1:0] out_read_data_o,
  output sbmq_pkg::status_e                  out_status_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned PtrW = $clog2(ENTRIES + 1);
  localparam int unsigned QW   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PtrW-1:0] LinkNull = PtrW'(ENTRIES);

  // latched item
  sbmq_pkg::cmd_e                     item_cmd_q;
  logic [sbmq_pkg::QIDX_W-1:0]        item_q_q;
  logic signed [sbmq_pkg::DATA_W-1:0] item_data_q;

  logic [31:0]   qin_ext, qitem_ext;
  logic [QW-1:0] qaddr_in, qaddr;
  logic          q_valid, q_nonempty;

  // per-queue {head, tail}
  logic [2*IdxW-1:0] qmem [QUEUES];
  logic [2*IdxW-1:0] qrd_q;
  logic [IdxW-1:0]   head_rd, tail_rd;
  logic [QUEUES-1:0] ne_q;

  logic [PtrW-1:0] link_mem [ENTRIES];
  logic [PtrW-1:0] link_rd_q, link_val;
  logic [PtrW-1:0] free_head_q, fill_q;
  logic [IdxW-1:0] link_raddr, idx_q;
  logic            fresh_q;
  logic            deq_last;

  logic                link_we;
  logic [IdxW-1:0]     link_waddr;
  logic [PtrW-1:0]     link_wdata;

  logic signed [sbmq_pkg::DATA_W-1:0] data_mem [ENTRIES];
  logic signed [sbmq_pkg::DATA_W-1:0] data_rd_q;

  logic signed [sbmq_pkg::DATA_W-1:0] res_data_q, out_data_q;
  sbmq_pkg::status_e                  res_status_q, out_status_q;

  assign qin_ext   = 32'(in_queue_index_i);
  assign qitem_ext = 32'(item_q_q);
  assign qaddr_in  = qin_ext[QW-1:0];
  assign qaddr     = qitem_ext[QW-1:0];

  assign q_valid    = qitem_ext < 32'(QUEUES);
  assign q_nonempty = q_valid && ne_q[qaddr];
  assign head_rd    = qrd_q[2*IdxW-1:IdxW];
  assign tail_rd    = qrd_q[IdxW-1:0];

  assign stat_o.is_deq     = (item_cmd_q == sbmq_pkg::CMD_DEQUEUE);
  assign stat_o.q_valid    = q_valid;
  assign stat_o.q_nonempty = q_nonempty;
  assign stat_o.free_empty = (free_head_q == LinkNull);

  // entries at or above the fill count were never written: next is index + 1
  assign link_raddr = cmd_i.read_enq ? free_head_q[IdxW-1:0] : head_rd;
  assign link_val   = fresh_q ? (PtrW'(idx_q) + PtrW'(1)) : link_rd_q;
  assign deq_last   = (idx_q == tail_rd) || (link_val >= LinkNull);

  always_comb begin
    link_we    = 1'b0;
    link_waddr = idx_q;
    link_wdata = LinkNull;
    priority if (cmd_i.commit_enq) begin
      link_we = 1'b1;
    end else if (cmd_i.link_tail) begin
      link_we    = 1'b1;
      link_waddr = tail_rd;
      link_wdata = PtrW'(idx_q);
    end else if (cmd_i.commit_deq) begin
      link_we    = 1'b1;
      link_wdata = free_head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_cmd_q  <= in_command_i;
      item_q_q    <= in_queue_index_i;
      item_data_q <= in_write_data_i;
      qrd_q       <= qmem[qaddr_in];
    end
    if (cmd_i.read_enq || cmd_i.read_deq) begin
      link_rd_q <= link_mem[link_raddr];
      data_rd_q <= data_mem[link_raddr];
      idx_q     <= link_raddr;
      fresh_q   <= (PtrW'(link_raddr) >= fill_q);
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd_i.commit_enq) begin
      data_mem[idx_q] <= item_data_q;
      qmem[qaddr]     <= {(q_nonempty ? head_rd : idx_q), idx_q};
    end else if (cmd_i.commit_deq && !deq_last) begin
      qmem[qaddr] <= {link_val[IdxW-1:0], tail_rd};
    end
    priority if (cmd_i.commit_enq) begin
      res_data_q   <= sbmq_pkg::DATA_ZERO;
      res_status_q <= sbmq_pkg::STAT_OK;
    end else if (cmd_i.commit_deq) begin
      res_data_q   <= data_rd_q;
      res_status_q <= sbmq_pkg::STAT_OK;
    end else if (cmd_i.set_ovf) begin
      res_data_q   <= sbmq_pkg::DATA_ZERO;
      res_status_q <= sbmq_pkg::STAT_OVERFLOW;
    end else if (cmd_i.set_udf) begin
      res_data_q   <= sbmq_pkg::DATA_UNDERFLOW;
      res_status_q <= sbmq_pkg::STAT_UNDERFLOW;
    end
    if (cmd_i.load_out) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q        <= '0;
      free_head_q <= '0;
      fill_q      <= '0;
    end else begin
      if (cmd_i.commit_enq) begin
        ne_q[qaddr] <= 1'b1;
        free_head_q <= link_val;
        if (fresh_q) begin
          fill_q <= fill_q + PtrW'(1);
        end
      end else if (cmd_i.commit_deq) begin
        if (deq_last) begin
          ne_q[qaddr] <= 1'b0;
        end
        free_head_q <= PtrW'(idx_q);
      end
    end
  end

  assign out_read_data_o = out_data_q;
  assign out_status_o    = out_status_q;

endmodule

// File: rtl/core/shared_buffer_multi_queue.sv
// Top level: several FIFO queues sharing one linked entry store with a free list.
//
//   channel  dir  handshake            payload
//   in_i     in   in_i.valid/ready     command, queue_index, write_data
//   out_o    out  out_o.valid/ready    read_data, status
//
// Every item gives one result. The sequencer steps through accept, look-up and output
// on overflow or underflow; a dequeue or an enqueue adds a commit step, and an enqueue
// to a nonempty queue also a link step (old tail linked via the one link write port).
// Reset is asynchronous, active low; the link memory uses a fill count, no clearing pass.
// One result can wait at the output while the next item runs; a second one stalls.
module shared_buffer_multi_queue #(
  parameter int unsigned ENTRIES = sbmq_pkg::ENTRIES_DEF,
  parameter int unsigned QUEUES  = sbmq_pkg::QUEUES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sbmq_in_if.sink           in_i,
  sbmq_out_if.source        out_o
);

  sbmq_pkg::ctl_cmd_t ctl_cmd;
  sbmq_pkg::dp_stat_t dp_stat;
  logic               in_ready;
  logic               out_valid;

  sbmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  sbmq_dp #(
    .ENTRIES (ENTRIES),
    .QUEUES  (QUEUES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctl_cmd),
    .stat_o           (dp_stat),
    .in_command_i     (in_i.command),
    .in_queue_index_i (in_i.queue_index),
    .in_write_data_i  (in_i.write_data),
    .out_read_data_o  (out_o.read_data),
    .out_status_o     (out_o.status)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // one item in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_single_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_cmd.commit_enq, ctl_cmd.commit_deq, ctl_cmd.set_ovf, ctl_cmd.set_udf}))
    else $error("more than one result source in a cycle");

  a_enq_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.commit_enq |-> (!dp_stat.free_empty && dp_stat.q_valid && !dp_stat.is_deq))
    else $error("enqueue committed without a free entry");

  a_deq_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.commit_deq |-> (dp_stat.q_nonempty && dp_stat.is_deq))
    else $error("dequeue committed on an empty queue");

  a_underflow_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_o.status == sbmq_pkg::STAT_UNDERFLOW) |-> (out_o.read_data == -1))
    else $error("underflow result without all-ones data");

endmodule

// File: sim/shared_buffer_multi_queue_tb.sv
// Self-checking testbench for the shared-buffer multi-queue with a free-list predictor.
module shared_buffer_multi_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbmq_pkg::*;

  localparam int unsigned N_ENT  = ENTRIES_DEF;
  localparam int unsigned N_Q    = QUEUES_DEF;
  localparam int unsigned PTR_W  = $clog2(N_ENT);
  localparam int unsigned LINK_W = $clog2(N_ENT + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(N_ENT);
  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned DRAIN_LIMIT = 5000;

  typedef struct {
    logic signed [DATA_W-1:0] read_data;
    status_e                  status;
  } queue_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sbmq_in_if  in_if ();
  sbmq_out_if out_if ();

  shared_buffer_multi_queue #(
    .ENTRIES (N_ENT),
    .QUEUES  (N_Q)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [PTR_W-1:0]         q_head [N_Q];
  logic [PTR_W-1:0]         q_tail [N_Q];
  logic                     q_busy [N_Q];
  logic [LINK_W-1:0]        next_link [N_ENT];
  logic [LINK_W-1:0]        free_top;
  logic signed [DATA_W-1:0] word_mem [N_ENT];

  queue_result_t pending_results [$];

  bit          no_idle;
  int unsigned mismatches;
  int unsigned n_items, n_enq, n_deq, n_ovf, n_udf, n_results;

  task automatic reset_queue_model();
    for (int i = 0; i < N_Q; i++) begin
      q_head[i] = '0;
      q_tail[i] = '0;
      q_busy[i] = 1'b0;
    end
    for (int i = 0; i < N_ENT; i++) begin
      next_link[i] = LINK_W'(i + 1);
      word_mem[i]  = DATA_ZERO;
    end
    free_top = '0;
  endtask

  function automatic queue_result_t apply_queue_op(cmd_e cmd, logic [QIDX_W-1:0] q,
                                                   logic signed [DATA_W-1:0] wdata);
    queue_result_t    res;
    logic [PTR_W-1:0] idx;
    res.read_data = DATA_ZERO;
    res.status    = STAT_OK;
    if (cmd == CMD_ENQUEUE) begin
      if (int'(q) >= N_Q || free_top == LINK_NULL) begin
        res.status = STAT_OVERFLOW;
      end else begin
        idx      = free_top[PTR_W-1:0];
        free_top = next_link[idx];
        if (q_busy[q]) next_link[q_tail[q]] = LINK_W'(idx);
        else q_head[q] = idx;
        next_link[idx] = LINK_NULL;
        q_tail[q]      = idx;
        q_busy[q]      = 1'b1;
        word_mem[idx]  = wdata;
      end
    end else begin
      if (int'(q) >= N_Q || !q_busy[q]) begin
        res.status    = STAT_UNDERFLOW;
        res.read_data = DATA_UNDERFLOW;
      end else begin
        idx = q_head[q];
        // last entry out: queue goes empty, head/tail left stale
        if (idx == q_tail[q] || next_link[idx] == LINK_NULL) q_busy[q] = 1'b0;
        else q_head[q] = next_link[idx][PTR_W-1:0];
        next_link[idx] = free_top;
        free_top       = LINK_W'(idx);
        res.read_data  = word_mem[idx];
      end
    end
    return res;
  endfunction

  task automatic send_item(cmd_e cmd, logic [QIDX_W-1:0] q, logic signed [DATA_W-1:0] wdata);
    queue_result_t res;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.queue_index <= q;
    in_if.write_data  <= wdata;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    res = apply_queue_op(cmd, q, wdata);
    pending_results.push_back(res);
    n_items++;
    if (cmd == CMD_ENQUEUE) n_enq++;
    else n_deq++;
    if (res.status == STAT_OVERFLOW) n_ovf++;
    if (res.status == STAT_UNDERFLOW) n_udf++;
  endtask

  // result checker and output back-pressure
  always @(posedge clk_i) begin
    queue_result_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result read_data=%0d status=%s",
                   $realtime, out_if.read_data, out_if.status.name());
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.read_data !== exp_res.read_data || out_if.status !== exp_res.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected read_data=%0d status=%s, got read_data=%0d status=%s",
                     $realtime, exp_res.read_data, exp_res.status.name(),
                     out_if.read_data, out_if.status.name());
        end
      end
    end
    out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic test_underflow_after_reset();
    for (int q = 0; q < N_Q; q++) send_item(CMD_DEQUEUE, QIDX_W'(q), DATA_W'($urandom));
    // single entry in and out, then the queue is empty again
    send_item(CMD_ENQUEUE, '0, 32'sh1234_5678);
    send_item(CMD_DEQUEUE, '0, '0);
    send_item(CMD_DEQUEUE, '0, '1);
  endtask

  task automatic test_fill_to_overflow();
    logic signed [DATA_W-1:0] word;
    for (int i = 0; i < N_ENT; i++) begin
      case (i % 4)
        0: word = 32'sh7FFF_FFFF;
        1: word = 32'sh8000_0000;
        2: word = DATA_ZERO;
        default: word = DATA_UNDERFLOW;
      endcase
      send_item(CMD_ENQUEUE, QIDX_W'(i % N_Q + i / 8), word);
    end
    send_item(CMD_ENQUEUE, QIDX_W'(N_Q - 1), DATA_W'($urandom));
  endtask

  // enq_pct biases toward filling or draining; a hot queue gets at least half the traffic
  task automatic test_random_traffic(int unsigned n, int unsigned enq_pct);
    logic [QIDX_W-1:0] hot_q;
    logic [QIDX_W-1:0] q;
    cmd_e              cmd;
    hot_q = QIDX_W'($urandom_range(N_Q - 1));
    for (int unsigned i = 0; i < n; i++) begin
      cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
      q   = $urandom_range(1) ? hot_q : QIDX_W'($urandom_range(N_Q - 1));
      send_item(cmd, q, DATA_W'($urandom));
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(300, 60);
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    rst_ni            = 1'b0;
    no_idle           = 1'b0;
    mismatches        = 0;
    n_items           = 0;
    n_enq             = 0;
    n_deq             = 0;
    n_ovf             = 0;
    n_udf             = 0;
    n_results         = 0;
    in_if.valid       = 1'b0;
    in_if.command     = CMD_ENQUEUE;
    in_if.queue_index = '0;
    in_if.write_data  = '0;
    out_if.ready      = 1'b0;
    reset_queue_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_underflow_after_reset();
    test_fill_to_overflow();
    test_random_traffic(300, 25);
    test_random_traffic(300, 75);
    test_back_to_back();
    test_random_traffic(300, 50);
    test_random_traffic(300, 40);
    test_random_traffic(200, 65);
    in_if.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_results.size());
    end

    $display("Sent %0d items (%0d enqueues, %0d dequeues), checked %0d results",
             n_items, n_enq, n_deq, n_results);
    $display("Overflows hit: %0d, underflows hit: %0d, failures: %0d", n_ovf, n_udf, mismatches);
    if (mismatches == 0) begin
      $display("shared_buffer_multi_queue_tb: clean");
    end else begin
      $display("shared_buffer_multi_queue_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("shared_buffer_multi_queue_tb: errors");
    $finish;
  end

endmodule

// File: files.f
rtl/core/sbmq_pkg.sv
rtl/core/sbmq_if.sv
rtl/core/sbmq_ctrl.sv
rtl/core/sbmq_dp.sv
rtl/core/shared_buffer_multi_queue.sv
sim/shared_buffer_multi_queue_tb.sv
